[src/ffb_pkg.sv]
// Shared types, request codes and defaults for the flame frame burn block.
package ffb_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int PIX_W = 8;

    localparam logic [7:0] RST_WIDTH   = 8'd128;
    localparam logic [6:0] RST_HEIGHT  = 7'd64;
    localparam logic [7:0] RST_COOLING = 8'd1;

    localparam logic [1:0] CFG_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_COOLING = 2'd2;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_BURN = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    // The four neighbors that feed one stencil update.
    typedef struct packed {
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] center;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] below;
    } taps_t;

endpackage

[src/flame_frame_burn.sv]
// Top level: request decode, clearing pass and burn sequencer around the frame store.
//
// After reset the block clears the frame store of MAX_WIDTH*MAX_HEIGHT pixels (8192
// by default) and the fuel row with busy high; configuration writes are taken at any
// time. A request is taken when start is high and busy is low, and its single result
// appears on pixel_value and out_of_range for exactly one cycle with done high; the
// receiver cannot stall it, so it must capture the beat in that cycle. A fuel load, an
// ignored code or an out-of-range request answers in the next cycle, a pixel read
// after passing through ST_READ and the done register. A burn is sequenced over the
// frame store one pixel per cycle within a row: the bottom row is blended from itself
// and the fuel row, each row above it is computed from its own pixels and the row
// below, and the read-compute-write pipeline is drained between rows, pausing the flow.
module flame_frame_burn #(
    parameter int MAX_WIDTH  = ffb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ffb_pkg::DEF_MAX_HEIGHT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic [6:0] column,
    input  logic [5:0] row,
    input  logic [7:0] fuel_value,
    output logic       done,
    output logic [7:0] pixel_value,
    output logic       out_of_range,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AWB   = CW + 1;
    localparam int AHB   = RW + 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_BLEND = 6'b001000,
        ST_ROW   = 6'b010000,
        ST_DRAIN = 6'b100000
    } state_t;

    function automatic logic [AW-1:0] frame_addr(input logic [RW-1:0] r,
                                                 input logic [CW-1:0] c);
        frame_addr = AW'(int'(r) * MAX_WIDTH + int'(c));
    endfunction

    state_t         state_reg, state_next;
    logic [7:0]     width_reg, width_next;
    logic [6:0]     height_reg, height_next;
    logic [7:0]     cooling_reg, cooling_next;
    logic [AW-1:0]  clr_addr_reg, clr_addr_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [RW-1:0]  r_reg, r_next;
    logic           rows_reg, rows_next;
    logic           done_reg, done_next;
    logic [7:0]     pix_reg, pix_next;
    logic           oor_reg, oor_next;
    logic           b_v_reg, b_v_next;
    logic           d_v_reg, d_v_next;
    logic           w_v_reg, w_v_next;
    logic [CW-1:0]  b_col_reg;
    logic [CW-1:0]  d_col_reg;
    logic [CW-1:0]  w_col_reg;
    logic [7:0]     p1_reg;
    logic [7:0]     p2_reg;

    logic [AWB-1:0] aw;
    logic [AHB-1:0] ah;
    logic [RW-1:0]  bottom;
    logic           accept;
    logic           col_oor;
    logic           row_oor;
    logic           last_col;
    logic           pipe_busy;
    logic [CW-1:0]  in_col;
    logic [RW-1:0]  in_row;

    logic           fr_we;
    logic [AW-1:0]  fr_waddr;
    logic [7:0]     fr_wdata;
    logic [AW-1:0]  fr_raddr_a;
    logic [AW-1:0]  fr_raddr_b;
    logic [7:0]     rd_a;
    logic [7:0]     rd_b;
    logic           fu_we;
    logic [CW-1:0]  fu_waddr;
    logic [7:0]     fu_wdata;
    logic [7:0]     fuel_rd;
    logic [9:0]     blend_sum;
    logic [7:0]     cooled;
    ffb_pkg::taps_t taps;

    // Active size is the configured size clamped to at least 1 and at most what the store holds.
    always_comb
    begin
        int wi;
        int hi;
        wi = int'(width_reg);
        hi = int'(height_reg);
        if (wi < 1)
        begin
            wi = 1;
        end
        if (wi > MAX_WIDTH)
        begin
            wi = MAX_WIDTH;
        end
        if (hi < 1)
        begin
            hi = 1;
        end
        if (hi > MAX_HEIGHT)
        begin
            hi = MAX_HEIGHT;
        end
        aw = AWB'(wi);
        ah = AHB'(hi);
    end

    assign bottom    = RW'(int'(ah) - 1);
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign col_oor   = int'(column) >= int'(aw);
    assign row_oor   = int'(row) >= int'(ah);
    assign in_col    = CW'(int'(column));
    assign in_row    = RW'(int'(row));
    assign last_col  = int'(k_reg) == int'(aw) - 1;
    assign pipe_busy = b_v_reg || d_v_reg || w_v_reg;

    // Read addresses: a pixel read takes port A straight from the request beat.
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            fr_raddr_a = frame_addr(in_row, in_col);
        end
        else if (state_reg == ST_BLEND)
        begin
            fr_raddr_a = frame_addr(bottom, k_reg);
        end
        else
        begin
            fr_raddr_a = frame_addr(r_reg, k_reg);
        end
        fr_raddr_b = frame_addr(r_reg + RW'(1), k_reg - CW'(1));
    end

    assign blend_sum = (10'(rd_a) * 10'd3) + 10'(fuel_rd);

    assign taps.left   = p2_reg;
    assign taps.center = p1_reg;
    assign taps.right  = rd_a;
    assign taps.below  = rd_b;

    always_comb
    begin
        priority if (state_reg == ST_CLEAR)
        begin
            fr_we    = 1'b1;
            fr_waddr = clr_addr_reg;
            fr_wdata = '0;
        end
        else if (w_v_reg)
        begin
            fr_we    = 1'b1;
            fr_waddr = frame_addr(r_reg, w_col_reg);
            fr_wdata = cooled;
        end
        else if (b_v_reg)
        begin
            fr_we    = 1'b1;
            fr_waddr = frame_addr(bottom, b_col_reg);
            fr_wdata = blend_sum[9:2];
        end
        else
        begin
            fr_we    = 1'b0;
            fr_waddr = clr_addr_reg;
            fr_wdata = '0;
        end
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            fu_we    = int'(clr_addr_reg) < MAX_WIDTH;
            fu_waddr = clr_addr_reg[CW-1:0];
            fu_wdata = '0;
        end
        else
        begin
            fu_we    = accept && (ffb_pkg::req_t'(req_type) == ffb_pkg::REQ_LOAD)
                       && !col_oor;
            fu_waddr = in_col;
            fu_wdata = fuel_value;
        end
    end

    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        cooling_next = cooling_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ffb_pkg::CFG_WIDTH:   width_next   = cfg_data;
                ffb_pkg::CFG_HEIGHT:  height_next  = cfg_data[6:0];
                ffb_pkg::CFG_COOLING: cooling_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        k_next        = k_reg;
        r_next        = r_reg;
        rows_next     = rows_reg;
        done_next     = 1'b0;
        pix_next      = '0;
        oor_next      = 1'b0;
        b_v_next      = (state_reg == ST_BLEND);
        d_v_next      = (state_reg == ST_ROW);
        w_v_next      = d_v_reg && (int'(d_col_reg) >= 2);

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (int'(clr_addr_reg) == DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (ffb_pkg::req_t'(req_type))
                        ffb_pkg::REQ_LOAD:
                        begin
                            done_next = 1'b1;
                            oor_next  = col_oor;
                        end
                        ffb_pkg::REQ_BURN:
                        begin
                            state_next = ST_BLEND;
                            k_next     = '0;
                            rows_next  = 1'b0;
                        end
                        ffb_pkg::REQ_READ:
                        begin
                            if (col_oor || row_oor)
                            begin
                                done_next = 1'b1;
                                oor_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                        ffb_pkg::REQ_NONE:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                done_next  = 1'b1;
                pix_next   = rd_a;
                state_next = ST_IDLE;
            end
            ST_BLEND, ST_ROW:
            begin
                if (last_col)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                end
            end
            ST_DRAIN:
            begin
                // The next row may read pixels still in flight, so wait for the pipe.
                if (!pipe_busy)
                begin
                    if ((!rows_reg && (int'(aw) < 3 || int'(bottom) == 0))
                        || (rows_reg && int'(r_reg) == 0))
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        r_next     = rows_reg ? (r_reg - RW'(1)) : (bottom - RW'(1));
                        rows_next  = 1'b1;
                        k_next     = '0;
                        state_next = ST_ROW;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            width_reg    <= ffb_pkg::RST_WIDTH;
            height_reg   <= ffb_pkg::RST_HEIGHT;
            cooling_reg  <= ffb_pkg::RST_COOLING;
            clr_addr_reg <= '0;
            k_reg        <= '0;
            r_reg        <= '0;
            rows_reg     <= 1'b0;
            done_reg     <= 1'b0;
            pix_reg      <= '0;
            oor_reg      <= 1'b0;
            b_v_reg      <= 1'b0;
            d_v_reg      <= 1'b0;
            w_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            cooling_reg  <= cooling_next;
            clr_addr_reg <= clr_addr_next;
            k_reg        <= k_next;
            r_reg        <= r_next;
            rows_reg     <= rows_next;
            done_reg     <= done_next;
            pix_reg      <= pix_next;
            oor_reg      <= oor_next;
            b_v_reg      <= b_v_next;
            d_v_reg      <= d_v_next;
            w_v_reg      <= w_v_next;
        end
    end

    // Pipeline payload: column tags and the two old pixels to the left of the read.
    always_ff @(posedge clk)
    begin
        b_col_reg <= k_reg;
        d_col_reg <= k_reg;
        w_col_reg <= d_col_reg - CW'(1);
        if (d_v_reg)
        begin
            p2_reg <= p1_reg;
            p1_reg <= rd_a;
        end
    end

    assign done         = done_reg;
    assign pixel_value  = pix_reg;
    assign out_of_range = oor_reg;

    ffb_frame_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_frame (
        .clk     (clk),
        .we      (fr_we),
        .waddr   (fr_waddr),
        .wdata   (fr_wdata),
        .raddr_a (fr_raddr_a),
        .rdata_a (rd_a),
        .raddr_b (fr_raddr_b),
        .rdata_b (rd_b)
    );

    ffb_fuel_ram #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (CW)
    ) u_fuel (
        .clk   (clk),
        .we    (fu_we),
        .waddr (fu_waddr),
        .wdata (fu_wdata),
        .raddr (k_reg),
        .rdata (fuel_rd)
    );

    ffb_stencil u_stencil (
        .clk     (clk),
        .taps    (taps),
        .cooling (cooling_reg),
        .value   (cooled)
    );

endmodule

[src/ffb_frame_ram.sv]
// Intensity frame store: one write port and two registered read ports.
module ffb_frame_ram #(
    parameter int DEPTH  = ffb_pkg::DEF_MAX_WIDTH * ffb_pkg::DEF_MAX_HEIGHT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [ffb_pkg::PIX_W-1:0] wdata,
    input  logic [ADDR_W-1:0]         raddr_a,
    output logic [ffb_pkg::PIX_W-1:0] rdata_a,
    input  logic [ADDR_W-1:0]         raddr_b,
    output logic [ffb_pkg::PIX_W-1:0] rdata_b
);

    logic [ffb_pkg::PIX_W-1:0] mem [DEPTH];
    logic [ffb_pkg::PIX_W-1:0] rd_a_reg;
    logic [ffb_pkg::PIX_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

[src/ffb_fuel_ram.sv]
// Fuel row store: one write port and one registered read port.
module ffb_fuel_ram #(
    parameter int DEPTH  = ffb_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [ffb_pkg::PIX_W-1:0] wdata,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [ffb_pkg::PIX_W-1:0] rdata
);

    logic [ffb_pkg::PIX_W-1:0] mem [DEPTH];
    logic [ffb_pkg::PIX_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;

endmodule

[src/ffb_stencil.sv]
// Two-stage fire stencil: weighted neighbor average, then cooling with a floor at zero.
module ffb_stencil (
    input  logic                      clk,
    input  ffb_pkg::taps_t            taps,
    input  logic [7:0]                cooling,
    output logic [ffb_pkg::PIX_W-1:0] value
);

    logic [11:0]               sum;
    logic [ffb_pkg::PIX_W-1:0] t_next;
    logic [ffb_pkg::PIX_W-1:0] t_reg;
    logic [16:0]               prod;
    logic [16:0]               bias;
    logic [16:0]               diff;

    always_comb
    begin
        sum = 12'(taps.left) + 12'(taps.right)
            + (12'(taps.center) * 12'd6) + {1'b0, taps.below, 3'b000};
        t_next = sum[11:4];
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
    end

    // Scaled value minus the cooling bias; anything at or below the bias burns out.
    always_comb
    begin
        prod = (17'd256 + 17'(cooling)) * 17'(t_reg);
        bias = {1'b0, cooling, 8'h00};
        diff = prod - bias;
        if (prod > bias)
        begin
            value = diff[15:8];
        end
        else
        begin
            value = '0;
        end
    end

endmodule
